// ===== rtl/core/bkl_pkg.sv =====
package bkl_pkg;

    localparam int THREAD_COUNT_DEF = 16;
    localparam int TICKET_BITS_DEF  = 16;
    localparam int THREAD_ID_BITS   = 4;
    localparam int TICKET_OUT_BITS  = 16;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_TICKET = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    // scan token handed from cell to cell
    typedef struct packed {
        logic [THREAD_ID_BITS-1:0]             thread_id;
        logic [TICKET_BITS_DEF-1:0]            top;
        logic [TICKET_BITS_DEF-1:0]            own;
        logic [TICKET_BITS_DEF-1:0]            min_ticket;
        logic                                  min_found;
        logic [$clog2(THREAD_COUNT_DEF)-1:0]   min_thread;
    } wave_def_t;

    // ticket write command broadcast to the cells
    typedef struct packed {
        logic                       en;
        logic [THREAD_ID_BITS-1:0]  thread_id;
        logic [TICKET_BITS_DEF-1:0] value;
    } wr_def_t;

endpackage

// ===== rtl/core/bkl_cell.sv =====
module bkl_cell import bkl_pkg::*; #(
    parameter int  TICKET_BITS = TICKET_BITS_DEF,
    parameter int  INDEX_BITS  = $clog2(THREAD_COUNT_DEF),
    parameter int  CELL_INDEX  = 0,
    parameter type wave_t      = wave_def_t,
    parameter type wr_t        = wr_def_t
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wave_valid_in,
    input  wave_t wave_in,
    output logic  wave_valid_out,
    output wave_t wave_out,
    input  wr_t   wr
);

    localparam int CMP_BITS = INDEX_BITS + THREAD_ID_BITS;
    localparam logic [CMP_BITS-1:0] MY_INDEX = CMP_BITS'(CELL_INDEX);

    logic [TICKET_BITS-1:0] ticket_reg;
    logic                   valid_reg;
    wave_t                  wave_reg;
    wave_t                  wave_next;
    logic                   scan_hit;
    logic                   wr_hit;

    assign scan_hit = ({{INDEX_BITS{1'b0}}, wave_in.thread_id} == MY_INDEX);
    assign wr_hit   = ({{INDEX_BITS{1'b0}}, wr.thread_id} == MY_INDEX);

    always_comb begin
        wave_next = wave_in;
        if (ticket_reg > wave_in.top) begin
            wave_next.top = ticket_reg;
        end
        if (scan_hit) begin
            wave_next.own = ticket_reg;
        end else if (ticket_reg != '0 &&
                     (!wave_in.min_found || ticket_reg < wave_in.min_ticket)) begin
            wave_next.min_ticket = ticket_reg;
            wave_next.min_found  = 1'b1;
            wave_next.min_thread = INDEX_BITS'(CELL_INDEX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticket_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= wave_valid_in;
            if (wr.en && wr_hit) begin
                ticket_reg <= wr.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wave_reg <= wave_next;
    end

    assign wave_valid_out = valid_reg;
    assign wave_out       = wave_reg;

endmodule

// ===== rtl/core/bakery_ticket_lock_arbiter.sv =====
// Bakery ticket lock arbiter. Each thread owns one ticket cell in a chain of
// THREAD_COUNT cells; zero means no ticket, and reset clears every cell. An
// acquire gives the thread the largest ticket in the table plus one (status 2
// and no ticket when that would overflow TICKET_BITS; no ticket for a thread
// index out of range), a release clears the thread's ticket (status 1 when it
// held none). Every result also reports the grant: the smallest nonzero
// ticket, ties to the lower thread index, after the update. A transaction
// launches a scan token that walks the chain one cell per cycle; the result
// is registered from the token's final value once the output can take it,
// and the next item is taken only after the result is registered.
module bakery_ticket_lock_arbiter import bkl_pkg::*; #(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int TICKET_BITS  = TICKET_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [THREAD_ID_BITS-1:0]  s_thread_id,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [TICKET_OUT_BITS-1:0] m_ticket_given,
    output logic                       m_grant_valid,
    output logic [THREAD_ID_BITS-1:0]  m_grant_thread
);

    localparam int IB = $clog2(THREAD_COUNT);
    localparam int CB = IB + THREAD_ID_BITS;

    typedef struct packed {
        logic [THREAD_ID_BITS-1:0] thread_id;
        logic [TICKET_BITS-1:0]    top;
        logic [TICKET_BITS-1:0]    own;
        logic [TICKET_BITS-1:0]    min_ticket;
        logic                      min_found;
        logic [IB-1:0]             min_thread;
    } wave_t;

    typedef struct packed {
        logic                      en;
        logic [THREAD_ID_BITS-1:0] thread_id;
        logic [TICKET_BITS-1:0]    value;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   op_reg;
    logic   in_range_reg;
    wave_t  final_reg;

    logic                       m_valid_reg;
    logic [1:0]                 status_reg;
    logic [TICKET_OUT_BITS-1:0] given_reg;
    logic                       grant_valid_reg;
    logic [THREAD_ID_BITS-1:0]  grant_thread_reg;

    logic  chain_valid [THREAD_COUNT+1];
    wave_t chain_wave  [THREAD_COUNT+1];
    wr_t   wr;

    logic                                    launch;
    logic                                    commit_fire;
    logic                                    commit_write;
    logic [TICKET_BITS-1:0]                  commit_value;
    logic [1:0]                              commit_status;
    logic [TICKET_BITS-1:0]                  commit_given;
    logic [TICKET_BITS-1:0]                  held;
    logic                                    own_live;
    logic                                    take_own;
    logic                                    commit_gvalid;
    logic [THREAD_ID_BITS-1:0]               commit_gthread;
    logic [TICKET_BITS+TICKET_OUT_BITS-1:0]  given_ext;
    logic [IB+THREAD_ID_BITS-1:0]            min_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign launch  = s_valid && s_ready;

    assign chain_valid[0]          = launch;
    assign chain_wave[0].thread_id = s_thread_id;
    assign chain_wave[0].top        = '0;
    assign chain_wave[0].own        = '0;
    assign chain_wave[0].min_ticket = '0;
    assign chain_wave[0].min_found  = 1'b0;
    assign chain_wave[0].min_thread = '0;

    for (genvar g = 0; g < THREAD_COUNT; g++) begin : g_cell
        bkl_cell #(
            .TICKET_BITS (TICKET_BITS),
            .INDEX_BITS  (IB),
            .CELL_INDEX  (g),
            .wave_t      (wave_t),
            .wr_t        (wr_t)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .wave_valid_in  (chain_valid[g]),
            .wave_in        (chain_wave[g]),
            .wave_valid_out (chain_valid[g+1]),
            .wave_out       (chain_wave[g+1]),
            .wr             (wr)
        );
    end

    assign commit_fire = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        commit_write  = 1'b0;
        commit_value  = '0;
        commit_status = STATUS_OK;
        commit_given  = '0;
        case (op_reg)
            OP_ACQUIRE: begin
                if (in_range_reg) begin
                    if (&final_reg.top) begin
                        commit_status = STATUS_OVERFLOW;
                    end else begin
                        commit_write = 1'b1;
                        commit_value = final_reg.top + TICKET_BITS'(1);
                        commit_given = commit_value;
                    end
                end
            end
            OP_RELEASE: begin
                if (in_range_reg && final_reg.own != '0) begin
                    commit_write = 1'b1;
                end else begin
                    commit_status = STATUS_NO_TICKET;
                end
            end
            default: begin
                commit_status = STATUS_OK;
            end
        endcase
    end

    assign held     = commit_write ? commit_value : final_reg.own;
    assign own_live = in_range_reg && (held != '0);
    assign take_own = own_live &&
                      (!final_reg.min_found || held < final_reg.min_ticket ||
                       (held == final_reg.min_ticket &&
                        {{IB{1'b0}}, final_reg.thread_id} <
                        {{THREAD_ID_BITS{1'b0}}, final_reg.min_thread}));
    assign min_ext  = {{THREAD_ID_BITS{1'b0}}, final_reg.min_thread};

    always_comb begin
        if (take_own) begin
            commit_gvalid  = 1'b1;
            commit_gthread = final_reg.thread_id;
        end else if (final_reg.min_found) begin
            commit_gvalid  = 1'b1;
            commit_gthread = min_ext[THREAD_ID_BITS-1:0];
        end else begin
            commit_gvalid  = 1'b0;
            commit_gthread = '0;
        end
    end

    assign given_ext = {{TICKET_OUT_BITS{1'b0}}, commit_given};

    assign wr.en        = commit_fire && commit_write;
    assign wr.thread_id = final_reg.thread_id;
    assign wr.value     = commit_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !commit_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= s_opcode;
                        in_range_reg <= ({{IB{1'b0}}, s_thread_id} < CB'(THREAD_COUNT));
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (chain_valid[THREAD_COUNT]) begin
                        final_reg <= chain_wave[THREAD_COUNT];
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (commit_fire) begin
                        m_valid_reg      <= 1'b1;
                        status_reg       <= commit_status;
                        given_reg        <= given_ext[TICKET_OUT_BITS-1:0];
                        grant_valid_reg  <= commit_gvalid;
                        grant_thread_reg <= commit_gthread;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_ticket_given = given_reg;
    assign m_grant_valid  = grant_valid_reg;
    assign m_grant_thread = grant_thread_reg;

endmodule

// ===== rtl/core/bkl_checker.sv =====
module bkl_checker import bkl_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_opcode,
    input logic [THREAD_ID_BITS-1:0]  s_thread_id,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic [TICKET_OUT_BITS-1:0] m_ticket_given,
    input logic                       m_grant_valid,
    input logic [THREAD_ID_BITS-1:0]  m_grant_thread
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_ticket_given) && $stable(m_grant_valid) && $stable(m_grant_thread))
        else $error("result changed while stalled");

    a_no_ticket_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_ticket_given == '0)
        else $error("ticket given with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK || m_status == STATUS_NO_TICKET ||
                     m_status == STATUS_OVERFLOW))
        else $error("undefined status code");

    a_grant_after_acquire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ticket_given != '0 |-> m_grant_valid)
        else $error("ticket given but no grant");

    a_idle_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_grant_valid |-> m_grant_thread == '0)
        else $error("grant thread set without grant");

endmodule

bind bakery_ticket_lock_arbiter bkl_checker u_bkl_checker (.*);
